[design/fdn_pkg.sv]
`timescale 1ns / 1ps

package fdn_pkg;

    localparam int SW        = 24;
    localparam int LINES     = 4;
    localparam int DEPTH     = 4096;
    localparam int AW        = 12;
    localparam int LEN_W     = 13;
    localparam int RAMP_W    = 16;
    localparam int TGT_W     = 22;
    localparam int FB_W      = 16;
    localparam int MA_W      = 27;
    localparam int MB_W      = 25;
    localparam int PROD_W    = 52;
    localparam int DIV_W     = 23;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [LEN_W-1:0] MIN_LEN   = 13'd8;
    localparam logic [LEN_W-1:0] MAX_LEN   = 13'd4096;
    localparam logic [LEN_W-1:0] AMT_MAX   = 13'd4096;

    localparam logic [LEN_W-1:0]  LEN_A_RST = 13'd1426;
    localparam logic [LEN_W-1:0]  LEN_B_RST = 13'd1781;
    localparam logic [LEN_W-1:0]  LEN_C_RST = 13'd1973;
    localparam logic [LEN_W-1:0]  LEN_D_RST = 13'd2559;
    localparam logic [RAMP_W-1:0] RAMP_RST  = 16'd2400;

    localparam logic signed [MB_W-1:0] C_FEED = 25'sd9175;
    localparam logic signed [MB_W-1:0] C_DAMP = 25'sd7864;
    localparam logic signed [MB_W-1:0] C_DUCK = 25'sd5898;
    localparam logic [FB_W-1:0]        C_FB_BASE = 16'd15073;
    localparam logic [12:0]            C_FB_SPAN = 13'd7209;
    localparam logic [13:0]            C_WET     = 14'd13763;

    localparam logic [2:0] REG_AMOUNT = 3'd0;
    localparam logic [2:0] REG_LEN_A  = 3'd1;
    localparam logic [2:0] REG_LEN_B  = 3'd2;
    localparam logic [2:0] REG_LEN_C  = 3'd3;
    localparam logic [2:0] REG_LEN_D  = 3'd4;
    localparam logic [2:0] REG_RAMP   = 3'd5;

    typedef logic signed [SW-1:0] sample_t;
    typedef logic [AW-1:0]        addr_t;

    typedef struct packed {
        logic [LINES-1:0][LEN_W-1:0] eff_len;
        logic [RAMP_W-1:0]           ramp;
        logic [TGT_W-1:0]            target;
        logic [FB_W-1:0]             fb;
    } cfg_t;

    typedef struct packed {
        logic             amt_start;
        logic [LINES-1:0] len_wr;
    } cfg_ev_t;

    typedef struct packed {
        logic                     rd_en;
        logic [LINES-1:0]         wr_en;
        logic [LINES-1:0][AW-1:0] addr;
        logic [SW-1:0]            wr_data;
    } bank_ctl_t;

    // Round half up, then arithmetic shift right.
    function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                          input int s);
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic sample_t sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = (PROD_W'(1) <<< (SW - 1)) - PROD_W'(1);
        lo = -hi - PROD_W'(1);
        if (v > hi) return hi[SW-1:0];
        else if (v < lo) return lo[SW-1:0];
        else return v[SW-1:0];
    endfunction

endpackage

[design/fdn_if.sv]
`timescale 1ns / 1ps

interface fdn_in_if import fdn_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t left_in;
    sample_t right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface fdn_out_if import fdn_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

[design/four_line_fdn_reverb.sv]
`timescale 1ns / 1ps

// Four-line feedback delay network reverb for stereo Q1.23 samples.
//
// Channels: sample_in carries one stereo pair per item (left_in, right_in);
// sample_out returns one processed pair per item (left_out, right_out). Both
// use valid/ready; an item moves when both are high at a rising clock edge.
// Registers are written over the APB-style port; pready is always high.
//
// Sequencing: one item is processed at a time. After an item is accepted, a
// sequencer runs 13 steps that share one 27x25 multiplier; the result is
// registered at the end of the last step, and only then can the next item be
// taken. The multiplier is the limit: each item needs twelve products. An
// amount write that changes the wet target with a nonzero ramp length starts
// the divider for the ramp increment; items are held off while it runs.
//
// Reset: the four delay lines are swept to zero, one address per cycle in all
// lines at once; no item is accepted meanwhile. Configuration writes are
// taken at any time.
//
// Stall: the result sits in an output register. If it has not been taken when
// the next result is done, the sequencer waits in its last step.

module four_line_fdn_reverb import fdn_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    fdn_in_if.sink             sample_in,
    fdn_out_if.source          sample_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DUCK  = 4'd2;
    localparam logic [3:0] ST_GAIN  = 4'd3;
    localparam logic [3:0] ST_FIN   = 4'd4;
    localparam logic [3:0] ST_WR_A  = 4'd5;
    localparam logic [3:0] ST_WR_B  = 4'd6;
    localparam logic [3:0] ST_WR_C  = 4'd7;
    localparam logic [3:0] ST_WR_D  = 4'd8;
    localparam logic [3:0] ST_SM_L  = 4'd9;
    localparam logic [3:0] ST_SM_R  = 4'd10;
    localparam logic [3:0] ST_DRY_L = 4'd11;
    localparam logic [3:0] ST_SUM_L = 4'd12;
    localparam logic [3:0] ST_DRY_R = 4'd13;
    localparam logic [3:0] ST_SUM_R = 4'd14;

    cfg_t    cfg;
    cfg_ev_t ev;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    addr_t       clr_cnt_reg;

    sample_t     l_reg;
    sample_t     r_reg;
    sample_t     feed_reg;
    sample_t     sl_reg;
    sample_t     sr_reg;
    sample_t     wet_reg;
    sample_t     inc_reg;
    logic [RAMP_W-1:0] ramp_left_reg;
    logic        div_neg_reg;
    logic [LINES-1:0][AW-1:0] pos_reg;

    logic signed [25:0]       all_reg;
    logic signed [MB_W-1:0]   gain_reg;
    logic signed [PROD_W-1:0] fin_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    sample_t     left_res_reg;
    sample_t     out_left_reg;
    sample_t     out_right_reg;
    logic        out_valid_reg;

    logic [LINES-1:0][SW-1:0] taps;
    sample_t     tap [LINES];
    logic [LINES-1:0][AW-1:0] wpos;
    logic [LINES-1:0][AW-1:0] npos;
    logic signed [MA_W-1:0]   diff [LINES];
    logic signed [MA_W-1:0]   sm_l;
    logic signed [MA_W-1:0]   sm_r;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [MB_W-1:0]   fb_s;
    logic signed [MB_W-1:0]   wet_b;
    sample_t     line_v;
    sample_t     right_v;
    bank_ctl_t   bank_ctl;

    logic        in_acc;
    logic        out_free;
    logic        div_busy;
    logic        div_done;
    logic [DIV_W-1:0] div_q;
    sample_t     tgt_s;
    sample_t     tgt_diff;
    logic [DIV_W-1:0] div_mag;
    logic [RAMP_W-1:0] ramp_dec;

    fdn_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .ev      (ev)
    );

    assign pready = 1'b1;

    // Ramp increment: |target - level| / ramp_samples, sign applied after.
    assign tgt_s    = SW'(cfg.target);
    assign tgt_diff = tgt_s - wet_reg;
    assign div_mag  = tgt_diff[SW-1] ? DIV_W'(-tgt_diff) : tgt_diff[DIV_W-1:0];

    fdn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ev.amt_start && (cfg.ramp != '0)),
        .dividend (div_mag),
        .divisor  (cfg.ramp),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    fdn_delay_bank u_bank (
        .clk  (clk),
        .ctl  (bank_ctl),
        .taps (taps)
    );

    assign sample_in.ready = (state_reg == ST_IDLE) && !ev.amt_start && (ev.len_wr == '0)
                             && !div_busy && !div_done;
    assign in_acc   = sample_in.valid && sample_in.ready;
    assign out_free = !out_valid_reg || sample_out.ready;

    // Position handling: wrap before the read, advance after the write.
    always_comb
    begin
        for (int i = 0; i < LINES; i++)
        begin
            logic [LEN_W-1:0] p1;
            p1      = {1'b0, pos_reg[i]} + LEN_W'(1);
            wpos[i] = ({1'b0, pos_reg[i]} >= cfg.eff_len[i]) ? '0 : pos_reg[i];
            npos[i] = (p1 >= cfg.eff_len[i]) ? '0 : p1[AW-1:0];
            tap[i]  = $signed(taps[i]);
            diff[i] = MA_W'(all_reg) - (MA_W'(tap[i]) <<< 1);
        end
    end

    assign sm_l  = MA_W'(tap[0]) + MA_W'(tap[2]) - (MA_W'(sl_reg) <<< 1);
    assign sm_r  = MA_W'(tap[1]) + MA_W'(tap[3]) - (MA_W'(sr_reg) <<< 1);
    assign fb_s  = $signed({{(MB_W-FB_W){1'b0}}, cfg.fb});
    assign wet_b = MB_W'(wet_reg);

    // Operand selection for the shared multiplier; each product lands in
    // prod_reg and is consumed by the following step.
    always_comb
    begin
        case (state_reg)
            ST_DUCK:
            begin
                mul_a = MA_W'(wet_reg);
                mul_b = C_DUCK;
            end
            ST_GAIN:
            begin
                mul_a = MA_W'(feed_reg);
                mul_b = C_FEED;
            end
            ST_FIN:
            begin
                mul_a = diff[0];
                mul_b = fb_s;
            end
            ST_WR_A:
            begin
                mul_a = diff[1];
                mul_b = fb_s;
            end
            ST_WR_B:
            begin
                mul_a = diff[2];
                mul_b = fb_s;
            end
            ST_WR_C:
            begin
                mul_a = diff[3];
                mul_b = fb_s;
            end
            ST_WR_D:
            begin
                mul_a = sm_l;
                mul_b = C_DAMP;
            end
            ST_SM_L:
            begin
                mul_a = sm_r;
                mul_b = C_DAMP;
            end
            ST_SM_R:
            begin
                mul_a = MA_W'(l_reg);
                mul_b = gain_reg;
            end
            ST_DRY_L:
            begin
                mul_a = MA_W'(sl_reg);
                mul_b = wet_b;
            end
            ST_SUM_L:
            begin
                mul_a = MA_W'(r_reg);
                mul_b = gain_reg;
            end
            ST_DRY_R:
            begin
                mul_a = MA_W'(sr_reg);
                mul_b = wet_b;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign line_v  = sat(rnd_shr(fin_reg + prod_reg, 16));
    assign right_v = sat(rnd_shr(acc_reg + prod_reg, 23));

    // Delay memory control: sweep on reset, read at accept, write per step.
    always_comb
    begin
        bank_ctl = '0;
        if (state_reg == ST_CLEAR)
        begin
            bank_ctl.wr_en = '1;
            for (int i = 0; i < LINES; i++)
            begin
                bank_ctl.addr[i] = clr_cnt_reg;
            end
        end
        else if (state_reg == ST_IDLE)
        begin
            bank_ctl.rd_en = in_acc;
            bank_ctl.addr  = wpos;
        end
        else
        begin
            bank_ctl.addr     = pos_reg;
            bank_ctl.wr_data  = line_v;
            bank_ctl.wr_en[0] = (state_reg == ST_WR_A);
            bank_ctl.wr_en[1] = (state_reg == ST_WR_B);
            bank_ctl.wr_en[2] = (state_reg == ST_WR_C);
            bank_ctl.wr_en[3] = (state_reg == ST_WR_D);
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_CLEAR: state_next = (clr_cnt_reg == addr_t'(DEPTH - 1)) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:  state_next = in_acc ? ST_DUCK : ST_IDLE;
            ST_DUCK:  state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_FIN;
            ST_FIN:   state_next = ST_WR_A;
            ST_WR_A:  state_next = ST_WR_B;
            ST_WR_B:  state_next = ST_WR_C;
            ST_WR_C:  state_next = ST_WR_D;
            ST_WR_D:  state_next = ST_SM_L;
            ST_SM_L:  state_next = ST_SM_R;
            ST_SM_R:  state_next = ST_DRY_L;
            ST_DRY_L: state_next = ST_SUM_L;
            ST_SUM_L: state_next = ST_DRY_R;
            ST_DRY_R: state_next = ST_SUM_R;
            ST_SUM_R: state_next = out_free ? ST_IDLE : ST_SUM_R;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign ramp_dec = ramp_left_reg - RAMP_W'(1);

    // Control state: sequencer, positions, smoothers, ramp and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            sl_reg        <= '0;
            sr_reg        <= '0;
            wet_reg       <= '0;
            inc_reg       <= '0;
            ramp_left_reg <= '0;
            div_neg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (sample_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            for (int i = 0; i < LINES; i++)
            begin
                if (ev.len_wr[i])
                begin
                    pos_reg[i] <= '0;
                end
            end

            // A new wet target either lands at once or starts a ramp.
            if (ev.amt_start)
            begin
                if (cfg.ramp == '0)
                begin
                    wet_reg       <= tgt_s;
                    ramp_left_reg <= '0;
                    inc_reg       <= '0;
                end
                else
                begin
                    ramp_left_reg <= cfg.ramp;
                    div_neg_reg   <= tgt_diff[SW-1];
                end
            end
            if (div_done)
            begin
                inc_reg <= div_neg_reg ? -SW'(div_q) : SW'(div_q);
            end

            unique case (state_reg)
                ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + addr_t'(1);
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        pos_reg <= wpos;
                        if (ramp_left_reg != '0)
                        begin
                            ramp_left_reg <= ramp_dec;
                            wet_reg <= (ramp_dec != '0) ? wet_reg + inc_reg : tgt_s;
                        end
                    end
                end
                ST_WR_A: pos_reg[0] <= npos[0];
                ST_WR_B: pos_reg[1] <= npos[1];
                ST_WR_C: pos_reg[2] <= npos[2];
                ST_WR_D: pos_reg[3] <= npos[3];
                ST_SM_L: sl_reg <= sat(PROD_W'(sl_reg) + rnd_shr(prod_reg, 16));
                ST_SM_R: sr_reg <= sat(PROD_W'(sr_reg) + rnd_shr(prod_reg, 16));
                ST_SUM_R:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    clr_cnt_reg <= clr_cnt_reg;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg != ST_SUM_R)
        begin
            prod_reg <= mul_p;
        end
        if (in_acc)
        begin
            l_reg    <= sample_in.left_in;
            r_reg    <= sample_in.right_in;
            feed_reg <= SW'((PROD_W'(sample_in.left_in) + PROD_W'(sample_in.right_in)
                        + PROD_W'(1)) >>> 1);
        end
        unique case (state_reg)
            ST_DUCK:
            begin
                all_reg <= 26'(tap[0]) + 26'(tap[1]) + 26'(tap[2]) + 26'(tap[3]);
            end
            ST_GAIN:
            begin
                gain_reg <= MB_W'((PROD_W'(1) <<< (SW - 1)) - rnd_shr(prod_reg, 15));
            end
            ST_FIN:   fin_reg <= prod_reg <<< 1;
            ST_DRY_L: acc_reg <= prod_reg;
            ST_SUM_L: left_res_reg <= sat(rnd_shr(acc_reg + prod_reg, 23));
            ST_DRY_R: acc_reg <= prod_reg;
            ST_SUM_R:
            begin
                if (out_free)
                begin
                    out_left_reg  <= left_res_reg;
                    out_right_reg <= right_v;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign sample_out.valid     = out_valid_reg;
    assign sample_out.left_out  = out_left_reg;
    assign sample_out.right_out = out_right_reg;

endmodule

[design/fdn_regs.sv]
`timescale 1ns / 1ps

module fdn_regs import fdn_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg,
    output cfg_ev_t            ev
);

    logic [LEN_W-1:0]              amount_reg;
    logic [LINES-1:0][LEN_W-1:0]   len_reg;
    logic [RAMP_W-1:0]             ramp_reg;
    logic [TGT_W-1:0]              target_reg;
    logic [FB_W-1:0]               fb_reg;
    cfg_ev_t                       ev_reg;

    logic             wr;
    logic [2:0]       idx;
    logic [LEN_W-1:0] v13;
    logic [LEN_W-1:0] amt_c;
    logic [26:0]      tgt_prod;
    logic [TGT_W-1:0] tgt_new;
    logic [25:0]      fb_prod;
    logic [FB_W-1:0]  fb_new;

    function automatic logic [LEN_W-1:0] eff(input logic [LEN_W-1:0] len);
        if (len < MIN_LEN) return MIN_LEN;
        else if (len > MAX_LEN) return MAX_LEN;
        else return len;
    endfunction

    assign wr       = psel & penable & pwrite;
    assign idx      = paddr[4:2];
    assign v13      = pwdata[LEN_W-1:0];
    assign amt_c    = (v13 > AMT_MAX) ? AMT_MAX : v13;
    assign tgt_prod = amt_c * C_WET;
    assign tgt_new  = TGT_W'((tgt_prod + 27'd8) >> 4);
    assign fb_prod  = amt_c * C_FB_SPAN;
    assign fb_new   = C_FB_BASE + FB_W'((fb_prod + 26'd2048) >> 12);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amount_reg <= '0;
            len_reg    <= {LEN_D_RST, LEN_C_RST, LEN_B_RST, LEN_A_RST};
            ramp_reg   <= RAMP_RST;
            target_reg <= '0;
            fb_reg     <= C_FB_BASE;
            ev_reg     <= '0;
        end
        else
        begin
            ev_reg <= '0;
            if (wr)
            begin
                case (idx)
                    REG_AMOUNT:
                    begin
                        amount_reg       <= v13;
                        target_reg       <= tgt_new;
                        fb_reg           <= fb_new;
                        ev_reg.amt_start <= (tgt_new != target_reg);
                    end
                    REG_LEN_A:
                    begin
                        len_reg[0]       <= v13;
                        ev_reg.len_wr[0] <= 1'b1;
                    end
                    REG_LEN_B:
                    begin
                        len_reg[1]       <= v13;
                        ev_reg.len_wr[1] <= 1'b1;
                    end
                    REG_LEN_C:
                    begin
                        len_reg[2]       <= v13;
                        ev_reg.len_wr[2] <= 1'b1;
                    end
                    REG_LEN_D:
                    begin
                        len_reg[3]       <= v13;
                        ev_reg.len_wr[3] <= 1'b1;
                    end
                    REG_RAMP:
                    begin
                        ramp_reg <= pwdata[RAMP_W-1:0];
                    end
                    default:
                    begin
                        ramp_reg <= ramp_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_AMOUNT: prdata = PDATA_W'(amount_reg);
            REG_LEN_A:  prdata = PDATA_W'(len_reg[0]);
            REG_LEN_B:  prdata = PDATA_W'(len_reg[1]);
            REG_LEN_C:  prdata = PDATA_W'(len_reg[2]);
            REG_LEN_D:  prdata = PDATA_W'(len_reg[3]);
            REG_RAMP:   prdata = PDATA_W'(ramp_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < LINES; i++)
        begin
            cfg.eff_len[i] = eff(len_reg[i]);
        end
        cfg.ramp   = ramp_reg;
        cfg.target = target_reg;
        cfg.fb     = fb_reg;
    end

    assign ev = ev_reg;

endmodule

[design/fdn_div.sv]
`timescale 1ns / 1ps

module fdn_div import fdn_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [RAMP_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    // Restoring division, one quotient bit per cycle.
    logic [DIV_W-1:0]  quo_reg;
    logic [RAMP_W-1:0] rem_reg;
    logic [RAMP_W-1:0] dvs_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [RAMP_W:0]   rem_sh;
    logic              fit;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign fit    = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fit ? RAMP_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[RAMP_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fit};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/fdn_delay_bank.sv]
`timescale 1ns / 1ps

module fdn_delay_bank import fdn_pkg::*; (
    input  logic                     clk,
    input  bank_ctl_t                ctl,
    output logic [LINES-1:0][SW-1:0] taps
);

    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        logic [SW-1:0] mem [DEPTH];
        logic [SW-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (ctl.wr_en[g])
            begin
                mem[ctl.addr[g]] <= ctl.wr_data;
            end
            if (ctl.rd_en)
            begin
                rd_reg <= mem[ctl.addr[g]];
            end
        end

        assign taps[g] = rd_reg;
    end

endmodule

[design/fdn_checker.sv]
`timescale 1ns / 1ps

module fdn_checker import fdn_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t left_out,
    input sample_t right_out,
    input logic    pready
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // A waiting result holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("result changed while stalled");

    // One item at a time: no item is taken in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("second item accepted while busy");

    // A result never appears right after its item is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(out_valid))
        else $error("result too early");

    // The delay lines are being cleared right after reset.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind four_line_fdn_reverb fdn_checker u_fdn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (sample_out.valid),
    .out_ready (sample_out.ready),
    .left_out  (sample_out.left_out),
    .right_out (sample_out.right_out),
    .pready    (pready)
);

[bench/four_line_fdn_reverb_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the four-line delay network reverb.
module four_line_fdn_reverb_test;
    import fdn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 400;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        sample_t        left;
        sample_t        right;
        bit             typed;
        sample_t        exp_left;
        sample_t        exp_right;
        logic [2:0]     reg_idx;
        int unsigned    reg_val;
    } stim_row_t;

    typedef struct {
        sample_t left;
        sample_t right;
    } pair_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    fdn_in_if  sin ();
    fdn_out_if sout ();

    four_line_fdn_reverb dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sin),
        .sample_out (sout),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the reverb state that the predictor advances.
    int          line_mem [LINES][DEPTH];
    int unsigned line_pos [LINES];
    int unsigned line_len [LINES];
    int unsigned amount_reg;
    int unsigned ramp_reg;
    longint      smooth_l;
    longint      smooth_r;
    longint      wet_mix;
    longint      wet_step;
    int unsigned ramp_count;

    pair_t     expected_pairs[$];
    stim_row_t directed_rows[$];

    int  mismatches;
    int  items_sent;
    int  pairs_checked;
    int  idle_cycles;
    bit  calm;
    bit  hold_req;
    bit  in_fire;
    bit  out_fire;

    // The clock runs free; reset is held only at the start.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The predictor mirrors the fixed-point datapath with 64-bit integers.
    function automatic longint round_shift(input longint v, input int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic longint clip(input longint v);
        longint hi;
        hi = (longint'(1) <<< (SW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint clamped_amount();
        return (amount_reg > 4096) ? 4096 : amount_reg;
    endfunction

    function automatic longint wet_goal(input longint a);
        return (a * longint'(C_WET) + 8) >>> 4;
    endfunction

    function automatic int unsigned line_limit(input int unsigned len);
        if (len < 8) return 8;
        if (len > DEPTH) return DEPTH;
        return len;
    endfunction

    function automatic longint duck_blend(input longint dry, input longint wet_sig,
                                          input longint mix);
        longint gain;
        gain = (longint'(1) <<< 23) - round_shift(mix * longint'(C_DUCK), 15);
        return clip(round_shift(dry * gain + wet_sig * mix, 23));
    endfunction

    function automatic void shadow_reg_write(input logic [2:0] idx, input int unsigned val);
        longint old_goal;
        longint new_goal;
        case (idx)
            REG_AMOUNT:
            begin
                old_goal = wet_goal(clamped_amount());
                amount_reg = val & 32'h1FFF;
                new_goal = wet_goal(clamped_amount());
                // Only a change of the wet target restarts the ramp.
                if (new_goal != old_goal)
                begin
                    if (ramp_reg == 0)
                    begin
                        wet_mix = new_goal;
                        ramp_count = 0;
                        wet_step = 0;
                    end
                    else
                    begin
                        ramp_count = ramp_reg;
                        wet_step = (new_goal - wet_mix) / longint'(ramp_reg);
                    end
                end
            end
            REG_LEN_A, REG_LEN_B, REG_LEN_C, REG_LEN_D:
            begin
                line_len[idx - REG_LEN_A] = val & 32'h1FFF;
                line_pos[idx - REG_LEN_A] = 0;
            end
            REG_RAMP: ramp_reg = val & 32'hFFFF;
            default: ;
        endcase
    endfunction

    function automatic pair_t reverb_predict(input sample_t l_in, input sample_t r_in);
        longint tap [LINES];
        longint feed;
        longint fb;
        longint total;
        longint fin;
        pair_t  res;
        feed = round_shift(longint'(l_in) + longint'(r_in), 1);
        fb = longint'(C_FB_BASE) + ((clamped_amount() * 7209 + 2048) >>> 12);
        total = 0;
        for (int i = 0; i < LINES; i++)
        begin
            if (line_pos[i] >= line_limit(line_len[i])) line_pos[i] = 0;
            tap[i] = line_mem[i][line_pos[i]];
            total += tap[i];
        end
        fin = feed * longint'(C_FEED) * 2;
        // Householder mix: each line gets the tap sum minus twice its own tap.
        for (int i = 0; i < LINES; i++)
        begin
            line_mem[i][line_pos[i]] = int'(clip(round_shift(fin + (total - 2 * tap[i]) * fb,
                                                             16)));
            line_pos[i]++;
            if (line_pos[i] >= line_limit(line_len[i])) line_pos[i] = 0;
        end
        smooth_l = clip(smooth_l + round_shift((tap[0] + tap[2] - 2 * smooth_l)
                                               * longint'(C_DAMP), 16));
        smooth_r = clip(smooth_r + round_shift((tap[1] + tap[3] - 2 * smooth_r)
                                               * longint'(C_DAMP), 16));
        if (ramp_count != 0)
        begin
            ramp_count--;
            if (ramp_count != 0) wet_mix += wet_step;
            else wet_mix = wet_goal(clamped_amount());
        end
        res.left  = sample_t'(duck_blend(longint'(l_in), smooth_l, wet_mix));
        res.right = sample_t'(duck_blend(longint'(r_in), smooth_r, wet_mix));
        return res;
    endfunction

    // Gaps are mostly absent or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return sample_t'($urandom);
        if (r < 8) return sample_t'($signed($urandom_range(0, 8191)) - 4096);
        return $urandom_range(0, 1) ? sample_t'(24'h7FFFFF) : sample_t'(24'h800000);
    endfunction

    // Lengths are mostly short so that echoes come back within a phase.
    function automatic int unsigned pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15) return $urandom_range(8, 40);
        if (r < 17) return $urandom_range(0, 7);
        if (r < 19) return $urandom_range(41, 8191);
        return 4096;
    endfunction

    function automatic void add_item(input int l, input int r);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.left = sample_t'(l);
        row.right = sample_t'(r);
        row.typed = 1'b0;
        directed_rows.push_back(row);
    endfunction

    // At reset the wet level is zero, so the output is the input unchanged.
    function automatic void add_passthrough(input int l, input int r);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.left = sample_t'(l);
        row.right = sample_t'(r);
        row.typed = 1'b1;
        row.exp_left = row.left;
        row.exp_right = row.right;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input int unsigned val);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    // One APB write: setup cycle, access cycle, then a return to idle.
    task automatic apb_write(input logic [2:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow_reg_write(idx, val);
        @(posedge clk);
    endtask

    // Registers change only with the block idle: every result back, plus a margin.
    task automatic wait_idle();
        while (expected_pairs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one pair after a random gap and hold it until the block takes it.
    task automatic send_pair(input sample_t l, input sample_t r, input bit typed,
                             input pair_t typed_exp);
        int    gap;
        pair_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            sin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sin.valid    <= 1'b1;
        sin.left_in  <= l;
        sin.right_in <= r;
        do @(posedge clk); while (!sin.ready);
        pred = reverb_predict(l, r);
        expected_pairs.push_back(typed ? typed_exp : pred);
        items_sent++;
    endtask

    task automatic close_stream();
        sin.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: checks every result and paces ready, including one long hold-off.
    initial begin : receiver
        int    out_gap;
        pair_t want;
        out_gap = 0;
        sout.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sout.valid && sout.ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result pair %0d/%0d", sout.left_out,
                                 sout.right_out);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (sout.left_out !== want.left || sout.right_out !== want.right)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("pair %0d: expected %0d/%0d, got %0d/%0d",
                                     pairs_checked, want.left, want.right,
                                     sout.left_out, sout.right_out);
                    end
                end
                pairs_checked++;
                out_gap = pick_gap();
            end
            if (hold_req)
            begin
                // Keep the output blocked long enough for the input to back up.
                sout.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_gap = 0;
            end
            else if (out_gap > 0)
            begin
                sout.ready <= 1'b0;
                out_gap--;
            end
            else
                sout.ready <= 1'b1;
        end
    end

    // Watchdog: too many cycles without any item moving ends the run.
    initial begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            in_fire = sin.valid && sin.ready;
            out_fire = sout.valid && sout.ready;
            if (in_fire || out_fire) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        pair_t       typed_exp;
        int unsigned n_items;
        stim_row_t   row;

        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        sin.valid    <= 1'b0;
        sin.left_in  <= '0;
        sin.right_in <= '0;
        mismatches    = 0;
        items_sent    = 0;
        pairs_checked = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;

        // Reset state of the shadow model.
        foreach (line_mem[i, j]) line_mem[i][j] = 0;
        foreach (line_pos[i]) line_pos[i] = 0;
        line_len[0] = LEN_A_RST;
        line_len[1] = LEN_B_RST;
        line_len[2] = LEN_C_RST;
        line_len[3] = LEN_D_RST;
        ramp_reg    = RAMP_RST;
        amount_reg  = 0;
        smooth_l    = 0;
        smooth_r    = 0;
        wet_mix     = 0;
        wet_step    = 0;
        ramp_count  = 0;

        // Directed table: extremes at reset pass straight through.
        add_passthrough(8388607, 8388607);
        add_passthrough(-8388608, -8388608);
        add_passthrough(0, 0);
        add_passthrough(-1, 1);
        add_passthrough(8388607, -8388608);
        add_passthrough(24'h555555, -24'h2AAAAB);
        // Zero ramp length: the full amount takes effect on the next pair.
        add_cfg(REG_RAMP, 0);
        add_cfg(REG_AMOUNT, 4096);
        add_item(8388607, 8388607);
        // Lengths below the minimum and above the depth are clamped; echoes of
        // the impulse come back after eight pairs on the shortest lines.
        add_cfg(REG_LEN_A, 0);
        add_cfg(REG_LEN_B, 8191);
        add_cfg(REG_LEN_C, 8);
        add_cfg(REG_LEN_D, 9);
        add_item(-8388608, 8388607);
        for (int k = 0; k < 8; k++) add_item(0, 0);
        // Amount above full scale gives the same target, so no ramp starts.
        add_cfg(REG_AMOUNT, 8191);
        add_item(100, -100);
        // One-step ramp, then a three-step ramp back toward half.
        add_cfg(REG_RAMP, 1);
        add_cfg(REG_AMOUNT, 0);
        add_item(-8388608, -8388608);
        add_cfg(REG_RAMP, 3);
        add_cfg(REG_AMOUNT, 2048);
        for (int k = 0; k < 4; k++) add_item(4000000, -4000000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG)
            begin
                close_stream();
                wait_idle();
                apb_write(row.reg_idx, row.reg_val);
            end
            else
            begin
                typed_exp.left = row.exp_left;
                typed_exp.right = row.exp_right;
                send_pair(row.left, row.right, row.typed, typed_exp);
            end
        end

        // Random phases: new settings, then a burst of pairs with random content.
        for (int phase = 0; phase < 9; phase++)
        begin
            close_stream();
            wait_idle();
            case (phase)
                0: apb_write(REG_RAMP, 65535);
                1: apb_write(REG_RAMP, 0);
                default: if ($urandom_range(0, 1)) apb_write(REG_RAMP, $urandom_range(1, 60));
            endcase
            for (int k = 0; k < 4; k++)
                if ($urandom_range(0, 2) != 0)
                    apb_write(3'(REG_LEN_A + k), pick_length());
            case ($urandom_range(0, 4))
                0: apb_write(REG_AMOUNT, 0);
                1: apb_write(REG_AMOUNT, 8191);
                2: apb_write(REG_AMOUNT, 4096);
                default: apb_write(REG_AMOUNT, $urandom_range(0, 8191));
            endcase
            calm = (phase == 4);
            if (phase == 2) hold_req = 1'b1;
            n_items = 78;
            for (int k = 0; k < n_items; k++)
                send_pair(pick_sample(), pick_sample(), 1'b0, typed_exp);
        end
        calm = 1'b0;
        close_stream();

        while (expected_pairs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d stereo pairs through directed and random phases, %0d results checked,",
                 items_sent, pairs_checked);
        $display("covering clamped lengths and amounts, wet ramps and a long output stall.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatching results", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
